@@ rtl/sin_tay_pkg.sv @@
// Shared constants and types for the degree-9 Taylor sine core.
// No dependencies; used by every module under rtl/.
package sin_tay_pkg;

    localparam int DATA_W          = 64;
    localparam int HALF_W          = 32;
    localparam int OUT_W           = 32;
    localparam int DIGIT_W         = 16;
    localparam int DIGITS          = 4;
    localparam int FRAC_Q          = 62;
    localparam int ANGLE_WIDTH_DEF = 32;
    localparam int HORNER_STEPS    = 4;

    // Q.56 fold constants, Q2.62 unity
    localparam logic [DATA_W-1:0] TWO_PI_Q56  = 64'h06487ED5110B4612;
    localparam logic [DATA_W-1:0] PI_Q56      = 64'h03243F6A8885A309;
    localparam logic [DATA_W-1:0] HALF_PI_Q56 = 64'h01921FB54442D185;
    localparam logic [DATA_W-1:0] ONE_Q62     = 64'h4000000000000000;

    localparam int HORNER_DIV [HORNER_STEPS] = '{72, 42, 20, 6};

    // cycles per block
    localparam int REDUCE_LAT = 5;
    localparam int MUL_LAT    = 3;
    localparam int HORNER_LAT = MUL_LAT + DIGITS + 1;
    localparam int LATENCY    = REDUCE_LAT + MUL_LAT + HORNER_STEPS * HORNER_LAT
                                + MUL_LAT + 2;

    typedef struct packed {
        logic              neg;
        logic [DATA_W-1:0] x;
    } side_t;

endpackage

@@ rtl/sin_tay_reduce.sv @@
// Angle reduction: sign split, two-pi folds, pi fold, pi/2 mirror.
// Depends on sin_tay_pkg. Five register stages, one request per cycle.
module sin_tay_reduce #(
    parameter int ANGLE_WIDTH = sin_tay_pkg::ANGLE_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               vld,
    input  logic [ANGLE_WIDTH-1:0]             angle,
    output logic                               x_vld,
    output logic [sin_tay_pkg::DATA_W-1:0]     x,
    output logic                               neg
);

    localparam int DW          = sin_tay_pkg::DATA_W;
    localparam int WIDEN_SHIFT = 61 - ANGLE_WIDTH;

    logic [sin_tay_pkg::REDUCE_LAT-1:0] vld_reg;
    logic [ANGLE_WIDTH-1:0]             mag_next;
    logic [DW-1:0] x1_reg, x2_reg, x3_reg, x4_reg, x5_reg;
    logic [DW-1:0] x2_next, x3_next, x4_next, x5_next;
    logic          neg1_reg, neg2_reg, neg3_reg, neg4_reg, neg5_reg;
    logic          neg4_next;

    assign mag_next = angle[ANGLE_WIDTH-1] ? (~angle + ANGLE_WIDTH'(1)) : angle;
    assign x2_next  = (x1_reg > sin_tay_pkg::TWO_PI_Q56) ? x1_reg - sin_tay_pkg::TWO_PI_Q56
                                                         : x1_reg;
    assign x3_next  = (x2_reg > sin_tay_pkg::TWO_PI_Q56) ? x2_reg - sin_tay_pkg::TWO_PI_Q56
                                                         : x2_reg;
    assign x4_next  = (x3_reg > sin_tay_pkg::PI_Q56) ? x3_reg - sin_tay_pkg::PI_Q56 : x3_reg;
    assign neg4_next = (x3_reg > sin_tay_pkg::PI_Q56) ? ~neg3_reg : neg3_reg;
    assign x5_next  = (x4_reg > sin_tay_pkg::HALF_PI_Q56) ? sin_tay_pkg::PI_Q56 - x4_reg
                                                          : x4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[sin_tay_pkg::REDUCE_LAT-2:0], vld};
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg   <= DW'(mag_next) << WIDEN_SHIFT;
        neg1_reg <= angle[ANGLE_WIDTH-1];
        x2_reg   <= x2_next;
        neg2_reg <= neg1_reg;
        x3_reg   <= x3_next;
        neg3_reg <= neg2_reg;
        x4_reg   <= x4_next;
        neg4_reg <= neg4_next;
        x5_reg   <= x5_next << 6;
        neg5_reg <= neg4_reg;
    end

    assign x_vld = vld_reg[sin_tay_pkg::REDUCE_LAT-1];
    assign x     = x5_reg;
    assign neg   = neg5_reg;

endmodule

@@ rtl/sin_tay_mul.sv @@
// Pipelined 64x64 Q2.62 multiplier, floor of the product over 2^62.
// Depends on sin_tay_pkg. Four 32x32 partial products, three stages.
module sin_tay_mul #(
    parameter int SIDE_W = 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           vld,
    input  logic [sin_tay_pkg::DATA_W-1:0] a,
    input  logic [sin_tay_pkg::DATA_W-1:0] b,
    input  logic [SIDE_W-1:0]              side,
    output logic                           prod_vld,
    output logic [sin_tay_pkg::DATA_W-1:0] prod,
    output logic [SIDE_W-1:0]              prod_side
);

    localparam int DW = sin_tay_pkg::DATA_W;
    localparam int H  = sin_tay_pkg::HALF_W;

    logic [sin_tay_pkg::MUL_LAT-1:0] vld_reg;
    logic [DW-1:0]     p0_reg, p1_reg, p2_reg, p3_reg;
    logic [DW:0]       mid_reg;
    logic [2*DW-1:0]   wide_reg;
    logic [2*DW-1:0]   full_next;
    logic [DW-1:0]     prod_reg;
    logic [SIDE_W-1:0] side1_reg, side2_reg, side3_reg;

    assign full_next = wide_reg + ((2*DW)'(mid_reg) << H);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[sin_tay_pkg::MUL_LAT-2:0], vld};
        end
    end

    always_ff @(posedge clk)
    begin
        p0_reg    <= DW'(a[H-1:0])  * DW'(b[H-1:0]);
        p1_reg    <= DW'(a[H-1:0])  * DW'(b[DW-1:H]);
        p2_reg    <= DW'(a[DW-1:H]) * DW'(b[H-1:0]);
        p3_reg    <= DW'(a[DW-1:H]) * DW'(b[DW-1:H]);
        side1_reg <= side;
        mid_reg   <= (DW+1)'(p1_reg) + (DW+1)'(p2_reg);
        wide_reg  <= {p3_reg, p0_reg};
        side2_reg <= side1_reg;
        prod_reg  <= full_next[sin_tay_pkg::FRAC_Q +: DW];
        side3_reg <= side2_reg;
    end

    assign prod_vld  = vld_reg[sin_tay_pkg::MUL_LAT-1];
    assign prod      = prod_reg;
    assign prod_side = side3_reg;

endmodule

@@ rtl/sin_tay_div_cell.sv @@
// One radix-2^16 digit of a 64-bit division by a small constant.
// Depends on sin_tay_pkg. Reciprocal estimate plus one correction step.
module sin_tay_div_cell #(
    parameter int DIVISOR = 6,
    parameter int DIGIT   = 0,
    parameter int SIDE_W  = 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           vld,
    input  logic [sin_tay_pkg::DATA_W-1:0] num,
    input  logic [sin_tay_pkg::DATA_W-1:0] quo,
    input  logic [$clog2(DIVISOR)-1:0]     rem,
    input  logic [SIDE_W-1:0]              side,
    output logic                           next_vld,
    output logic [sin_tay_pkg::DATA_W-1:0] next_num,
    output logic [sin_tay_pkg::DATA_W-1:0] next_quo,
    output logic [$clog2(DIVISOR)-1:0]     next_rem,
    output logic [SIDE_W-1:0]              next_side
);

    localparam int DW    = sin_tay_pkg::DATA_W;
    localparam int GW    = sin_tay_pkg::DIGIT_W;
    localparam int REM_W = $clog2(DIVISOR);
    localparam int V_W   = REM_W + GW;
    localparam logic [V_W-1:0] KV    = V_W'(DIVISOR);
    localparam logic [V_W-1:0] RECIP = V_W'((64'd1 << V_W) / DIVISOR);

    logic [V_W-1:0]   v;
    logic [2*V_W-1:0] est;
    logic [V_W-1:0]   q_est, kq, r_est, q_fin, r_fin;
    logic             fix;
    logic [DW-1:0]    quo_next;

    logic             vld_reg;
    logic [DW-1:0]    num_reg, quo_reg;
    logic [REM_W-1:0] rem_reg;
    logic [SIDE_W-1:0] side_reg;

    always_comb
    begin
        v     = {rem, num[DIGIT*GW +: GW]};
        est   = (2*V_W)'(v) * (2*V_W)'(RECIP);
        q_est = est[2*V_W-1:V_W];
        kq    = q_est * KV;
        r_est = v - kq;
        fix   = (r_est >= KV);
        q_fin = fix ? q_est + V_W'(1) : q_est;
        r_fin = fix ? r_est - KV : r_est;
        quo_next = quo;
        quo_next[DIGIT*GW +: GW] = q_fin[GW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num;
        quo_reg  <= quo_next;
        rem_reg  <= r_fin[REM_W-1:0];
        side_reg <= side;
    end

    assign next_vld  = vld_reg;
    assign next_num  = num_reg;
    assign next_quo  = quo_reg;
    assign next_rem  = rem_reg;
    assign next_side = side_reg;

endmodule

@@ rtl/sin_tay_horner_cell.sv @@
// One Horner step: t' = 1 - floor(s*t)/DIVISOR, all Q2.62.
// Depends on sin_tay_pkg, sin_tay_mul and sin_tay_div_cell.
module sin_tay_horner_cell #(
    parameter int DIVISOR = 6
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           vld,
    input  logic [sin_tay_pkg::DATA_W-1:0] s,
    input  logic [sin_tay_pkg::DATA_W-1:0] t,
    input  sin_tay_pkg::side_t             side,
    output logic                           next_vld,
    output logic [sin_tay_pkg::DATA_W-1:0] next_s,
    output logic [sin_tay_pkg::DATA_W-1:0] next_t,
    output sin_tay_pkg::side_t             next_side
);

    localparam int DW     = sin_tay_pkg::DATA_W;
    localparam int ND     = sin_tay_pkg::DIGITS;
    localparam int REM_W  = $clog2(DIVISOR);
    localparam int CARRY_W = DW + $bits(sin_tay_pkg::side_t);

    logic               d_vld  [0:ND];
    logic [DW-1:0]      d_num  [0:ND];
    logic [DW-1:0]      d_quo  [0:ND];
    logic [REM_W-1:0]   d_rem  [0:ND];
    logic [CARRY_W-1:0] d_side [0:ND];

    logic               vld_reg;
    logic [DW-1:0]      s_reg, t_reg;
    sin_tay_pkg::side_t side_reg;

    sin_tay_mul #(
        .SIDE_W (CARRY_W)
    ) u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .vld       (vld),
        .a         (s),
        .b         (t),
        .side      ({s, side}),
        .prod_vld  (d_vld[0]),
        .prod      (d_num[0]),
        .prod_side (d_side[0])
    );

    assign d_quo[0] = '0;
    assign d_rem[0] = '0;

    for (genvar i = 0; i < ND; i++)
    begin : g_div
        sin_tay_div_cell #(
            .DIVISOR (DIVISOR),
            .DIGIT   (ND - 1 - i),
            .SIDE_W  (CARRY_W)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .vld       (d_vld[i]),
            .num       (d_num[i]),
            .quo       (d_quo[i]),
            .rem       (d_rem[i]),
            .side      (d_side[i]),
            .next_vld  (d_vld[i+1]),
            .next_num  (d_num[i+1]),
            .next_quo  (d_quo[i+1]),
            .next_rem  (d_rem[i+1]),
            .next_side (d_side[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= d_vld[ND];
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg    <= sin_tay_pkg::ONE_Q62 - d_quo[ND];
        s_reg    <= d_side[ND][CARRY_W-1 -: DW];
        side_reg <= d_side[ND][CARRY_W-DW-1:0];
    end

    assign next_vld  = vld_reg;
    assign next_s    = s_reg;
    assign next_t    = t_reg;
    assign next_side = side_reg;

endmodule

@@ rtl/sine_taylor_approx_core.sv @@
// Degree-9 Taylor sine core: reduction, x^2, four Horner cells, final x*t, rounding.
// Each accepted start yields its own done strobe.
// Throughput: one request per cycle; busy is always low, the pipeline never stalls.
// Latency is set by the reduce, multiply, digit-per-cycle divide and rounding stages.
// Reset clears all valid bits; requests in flight are dropped. Depends on sin_tay_pkg.
module sine_taylor_approx_core #(
    parameter int ANGLE_WIDTH = sin_tay_pkg::ANGLE_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [ANGLE_WIDTH-1:0]         angle,
    output logic                                  done,
    output logic signed [sin_tay_pkg::OUT_W-1:0]  sine_value
);

    localparam int DW  = sin_tay_pkg::DATA_W;
    localparam int OW  = sin_tay_pkg::OUT_W;
    localparam int NH  = sin_tay_pkg::HORNER_STEPS;
    localparam int LAT = sin_tay_pkg::LATENCY;
    localparam logic [DW-1:0] RND_HALF = DW'(1) << (DW - OW - 1);
    localparam logic [ANGLE_WIDTH-1:0] PI_IN =
        ANGLE_WIDTH'(sin_tay_pkg::PI_Q56 >> (61 - ANGLE_WIDTH));
    localparam logic signed [OW-1:0] PEAK_BOUND = OW'((64'd1 << 30) + (64'd1 << 12));

    logic               r_vld;
    logic [DW-1:0]      r_x;
    logic               r_neg;
    sin_tay_pkg::side_t r_side;

    logic               h_vld  [0:NH];
    logic [DW-1:0]      h_s    [0:NH];
    logic [DW-1:0]      h_t    [0:NH];
    sin_tay_pkg::side_t h_side [0:NH];

    logic               f_vld;
    logic [DW-1:0]      f_r;
    logic               f_neg;

    logic               rnd_vld_reg, done_reg;
    logic [OW-1:0]      rnd_reg, sine_reg;
    logic               rnd_neg_reg;
    logic [DW-1:0]      rnd_next;

    assign busy = 1'b0;

    sin_tay_reduce #(
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_reduce (
        .clk   (clk),
        .rst_n (rst_n),
        .vld   (start),
        .angle (angle),
        .x_vld (r_vld),
        .x     (r_x),
        .neg   (r_neg)
    );

    assign r_side.neg = r_neg;
    assign r_side.x   = r_x;

    sin_tay_mul #(
        .SIDE_W ($bits(sin_tay_pkg::side_t))
    ) u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .vld       (r_vld),
        .a         (r_x),
        .b         (r_x),
        .side      (r_side),
        .prod_vld  (h_vld[0]),
        .prod      (h_s[0]),
        .prod_side (h_side[0])
    );

    assign h_t[0] = sin_tay_pkg::ONE_Q62;

    for (genvar i = 0; i < NH; i++)
    begin : g_horner
        sin_tay_horner_cell #(
            .DIVISOR (sin_tay_pkg::HORNER_DIV[i])
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .vld       (h_vld[i]),
            .s         (h_s[i]),
            .t         (h_t[i]),
            .side      (h_side[i]),
            .next_vld  (h_vld[i+1]),
            .next_s    (h_s[i+1]),
            .next_t    (h_t[i+1]),
            .next_side (h_side[i+1])
        );
    end

    sin_tay_mul #(
        .SIDE_W (1)
    ) u_final (
        .clk       (clk),
        .rst_n     (rst_n),
        .vld       (h_vld[NH]),
        .a         (h_side[NH].x),
        .b         (h_t[NH]),
        .side      (h_side[NH].neg),
        .prod_vld  (f_vld),
        .prod      (f_r),
        .prod_side (f_neg)
    );

    assign rnd_next = f_r + RND_HALF;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            rnd_vld_reg <= f_vld;
            done_reg    <= rnd_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rnd_reg     <= rnd_next[DW-1 -: OW];
        rnd_neg_reg <= f_neg;
        sine_reg    <= rnd_neg_reg ? (~rnd_reg + OW'(1)) : rnd_reg;
    end

    assign done       = done_reg;
    assign sine_value = $signed(sine_reg);

    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("request did not complete after fixed latency");

    a_latency_bwd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("done strobe without matching request");

    a_peak: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (sine_value <= PEAK_BOUND && sine_value >= -PEAK_BOUND))
        else $error("sine magnitude out of range");

    a_sign_first_half: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !angle[ANGLE_WIDTH-1] && $unsigned(angle) < PI_IN)
            |-> ##LAT !sine_value[OW-1])
        else $error("negative sine for angle in zero to pi");

endmodule
